### rtl/cmos_rtc_register_file_unit_macros.svh
// assertion macros shared by the rtc checker
`ifndef CMOS_RTC_REGISTER_FILE_UNIT_MACROS_SVH
`define CMOS_RTC_REGISTER_FILE_UNIT_MACROS_SVH

// same-cycle implication, checked on every clk edge outside reset
`define CRTC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CRTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/crtc_pkg.sv
// constants and types of the cmos rtc register file
package crtc_pkg;

  localparam int MAIN_DEPTH = 128;
  localparam int EXT_DEPTH  = 128;
  localparam int MAIN_AW    = $clog2(MAIN_DEPTH);
  localparam int EXT_AW     = $clog2(EXT_DEPTH);

  // depth limits as 8-bit values for compares against a 7-bit index
  localparam logic [7:0] MAIN_LIM = 8'(MAIN_DEPTH);
  localparam logic [7:0] EXT_LIM  = 8'(EXT_DEPTH);

  localparam logic [6:0] IDX_SEC      = 7'h00;
  localparam logic [6:0] IDX_MIN      = 7'h02;
  localparam logic [6:0] IDX_HOUR     = 7'h04;
  localparam logic [6:0] IDX_WDAY     = 7'h06;
  localparam logic [6:0] IDX_DAY      = 7'h07;
  localparam logic [6:0] IDX_MON      = 7'h08;
  localparam logic [6:0] IDX_YEAR     = 7'h09;
  localparam logic [6:0] IDX_A        = 7'h0A;
  localparam logic [6:0] IDX_B        = 7'h0B;
  localparam logic [6:0] IDX_C        = 7'h0C;
  localparam logic [6:0] IDX_D        = 7'h0D;
  localparam logic [6:0] IDX_EXT_PTR  = 7'h3D;
  localparam logic [6:0] IDX_EXT_DATA = 7'h3F;

  localparam logic [7:0] BYTE_NONE  = 8'hFF;
  localparam logic [7:0] BYTE_ZERO  = 8'h00;
  localparam logic [7:0] C_IRQ_FLAG = 8'hC0;
  localparam logic [7:0] D_VRT      = 8'h80;

  localparam logic [2:0] TICK_LAST = 3'd7;

  typedef enum logic [2:0] {
    OP_IDX_WR  = 3'd0,
    OP_IDX_RD  = 3'd1,
    OP_DATA_RD = 3'd2,
    OP_DATA_WR = 3'd3,
    OP_TICK    = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MAIN_RD,
    ST_EXT_RD,
    ST_TICK,
    ST_DONE
  } state_t;

endpackage

### rtl/cmos_rtc_register_file_unit.sv
// index/data cmos rtc register file with a time-load sequencer
//
// Input channel (in_valid/in_ready) carries one operation per transaction:
// index write, index read, data read, data write or tick, plus the binary
// time fields used by a tick. The result channel (out_valid/out_ready)
// returns exactly one transaction per input: read byte, irq, rate_changed
// and rate_select.
// States per item: decode, then done for index ops, unused ops and main
// store writes; main read first for data reads, extended store writes and
// ticks; an extended store read adds ext read, a tick adds its tick steps.
// The tick steps run one after another because of the single write port
// of the main store and the shared bcd converter: C, then each of the seven
// time bytes, which SET skips. in_ready is high only while the sequencer is
// idle; the next item can be accepted while a finished result still waits
// in the output register. If the receiver stalls, the sequencer holds its
// finished result until the output register frees. Reset clears the index
// and the valid bits of both stores, so unwritten bytes read as zero, but
// a read of D returns and sets VRT, and bit 7 of a read of A shows the
// in_updating flag of the transaction.
module cmos_rtc_register_file_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_op,
  input  logic [7:0] in_data,
  input  logic [5:0] in_second,
  input  logic [5:0] in_minute,
  input  logic [4:0] in_hour,
  input  logic [2:0] in_weekday,
  input  logic [4:0] in_day,
  input  logic [3:0] in_month,
  input  logic [6:0] in_year,
  input  logic       in_updating,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_data,
  output logic       out_irq,
  output logic       out_rate_changed,
  output logic [3:0] out_rate_select
);

  crtc_pkg::state_t state_r, state_nxt;

  // latched transaction
  logic [2:0] op_r;
  logic [7:0] data_r;
  logic [5:0] sec_r;
  logic [5:0] min_r;
  logic [4:0] hour_r;
  logic [2:0] wday_r;
  logic [4:0] day_r;
  logic [3:0] mon_r;
  logic [6:0] year_r;
  logic       upd_r;

  logic [6:0] reg_index_r, reg_index_nxt;
  logic [7:0] b_r, b_nxt;
  logic [2:0] step_r, step_nxt;

  logic [7:0] res_rd_r, res_rd_nxt;
  logic       res_irq_r, res_irq_nxt;
  logic       res_chg_r, res_chg_nxt;
  logic [3:0] res_sel_r, res_sel_nxt;

  logic       out_valid_r;
  logic [7:0] out_rd_r;
  logic       out_irq_r;
  logic       out_chg_r;
  logic [3:0] out_sel_r;
  logic       out_load;

  // main store
  logic [7:0]                     main_mem [crtc_pkg::MAIN_DEPTH];
  logic [crtc_pkg::MAIN_DEPTH-1:0] main_vld_r;
  logic                           main_we;
  logic [6:0]                     main_waddr;
  logic [7:0]                     main_wdata;
  logic [6:0]                     main_raddr;
  logic [7:0]                     main_rd_r;
  logic                           main_rv_r;
  logic [7:0]                     mval;

  // extended store
  logic [7:0]                    ext_mem [crtc_pkg::EXT_DEPTH];
  logic [crtc_pkg::EXT_DEPTH-1:0] ext_vld_r;
  logic                          ext_we;
  logic [6:0]                    ext_addr;
  logic [7:0]                    ext_rd_r;
  logic                          ext_rv_r;
  logic [7:0]                    ext_val;

  logic       in_acc;
  logic       idx_in_main;
  logic       idx_is_ext;
  logic       ptr_in_ext;

  // shared bcd converter
  logic [6:0]  bcd_in;
  logic [6:0]  tick_addr;
  logic [14:0] bcd_prod;
  logic [3:0]  bcd_tens;
  logic [6:0]  bcd_ones;
  logic [3:0]  bcd_hi;
  logic [7:0]  bcd_out;

  assign in_ready = (state_r == crtc_pkg::ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  assign out_valid        = out_valid_r;
  assign out_read_data    = out_rd_r;
  assign out_irq          = out_irq_r;
  assign out_rate_changed = out_chg_r;
  assign out_rate_select  = out_sel_r;

  assign idx_in_main = ({1'b0, reg_index_r} < crtc_pkg::MAIN_LIM);
  assign idx_is_ext  = (reg_index_r == crtc_pkg::IDX_EXT_DATA);
  assign mval        = main_rv_r ? main_rd_r : crtc_pkg::BYTE_ZERO;
  assign ext_val     = ext_rv_r ? ext_rd_r : crtc_pkg::BYTE_ZERO;
  assign ptr_in_ext  = ({1'b0, mval[6:0]} < crtc_pkg::EXT_LIM);
  assign ext_addr    = mval[6:0];

  // time field and target byte for each tick step
  always_comb begin
    case (step_r)
      3'd1: begin
        bcd_in    = {1'b0, sec_r};
        tick_addr = crtc_pkg::IDX_SEC;
      end
      3'd2: begin
        bcd_in    = {1'b0, min_r};
        tick_addr = crtc_pkg::IDX_MIN;
      end
      3'd3: begin
        bcd_in    = {2'b00, hour_r};
        tick_addr = crtc_pkg::IDX_HOUR;
      end
      3'd4: begin
        bcd_in    = {4'b0000, wday_r};
        tick_addr = crtc_pkg::IDX_WDAY;
      end
      3'd5: begin
        bcd_in    = {2'b00, day_r};
        tick_addr = crtc_pkg::IDX_DAY;
      end
      3'd6: begin
        bcd_in    = {3'b000, mon_r};
        tick_addr = crtc_pkg::IDX_MON;
      end
      default: begin
        bcd_in    = year_r;
        tick_addr = crtc_pkg::IDX_YEAR;
      end
    endcase
  end

  // v / 10 as (v * 205) >> 11, exact for every 7-bit value
  assign bcd_prod = 15'(bcd_in) * 15'd205;
  assign bcd_tens = bcd_prod[14:11];
  assign bcd_ones = bcd_in - 7'(bcd_tens) * 7'd10;
  assign bcd_hi   = (bcd_tens >= 4'd10) ? (bcd_tens - 4'd10) : bcd_tens;
  assign bcd_out  = {bcd_hi, bcd_ones[3:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= crtc_pkg::ST_IDLE;
      reg_index_r <= '0;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      reg_index_r <= reg_index_nxt;
      step_r      <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_op;
      data_r <= in_data;
      sec_r  <= in_second;
      min_r  <= in_minute;
      hour_r <= in_hour;
      wday_r <= in_weekday;
      day_r  <= in_day;
      mon_r  <= in_month;
      year_r <= in_year;
      upd_r  <= in_updating;
    end
    b_r       <= b_nxt;
    res_rd_r  <= res_rd_nxt;
    res_irq_r <= res_irq_nxt;
    res_chg_r <= res_chg_nxt;
    res_sel_r <= res_sel_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    reg_index_nxt = reg_index_r;
    b_nxt         = b_r;
    step_nxt      = step_r;
    res_rd_nxt    = res_rd_r;
    res_irq_nxt   = res_irq_r;
    res_chg_nxt   = res_chg_r;
    res_sel_nxt   = res_sel_r;
    main_we       = 1'b0;
    main_waddr    = reg_index_r;
    main_wdata    = data_r;
    main_raddr    = reg_index_r;
    ext_we        = 1'b0;
    out_load      = 1'b0;

    case (state_r)
      crtc_pkg::ST_IDLE: begin
        res_rd_nxt  = crtc_pkg::BYTE_NONE;
        res_irq_nxt = 1'b0;
        res_chg_nxt = 1'b0;
        res_sel_nxt = 4'd0;
        if (in_valid) begin
          state_nxt = crtc_pkg::ST_DECODE;
        end
      end

      crtc_pkg::ST_DECODE: begin
        state_nxt = crtc_pkg::ST_DONE;
        case (op_r)
          crtc_pkg::OP_IDX_WR: begin
            reg_index_nxt = data_r[6:0];
          end
          crtc_pkg::OP_DATA_RD: begin
            if (idx_is_ext) begin
              main_raddr = crtc_pkg::IDX_EXT_PTR;
              state_nxt  = crtc_pkg::ST_MAIN_RD;
            end else if (idx_in_main) begin
              state_nxt = crtc_pkg::ST_MAIN_RD;
            end
          end
          crtc_pkg::OP_DATA_WR: begin
            if (idx_is_ext) begin
              main_raddr = crtc_pkg::IDX_EXT_PTR;
              state_nxt  = crtc_pkg::ST_MAIN_RD;
            end else begin
              main_we = idx_in_main;
              if (reg_index_r == crtc_pkg::IDX_A) begin
                res_chg_nxt = 1'b1;
                res_sel_nxt = data_r[3:0];
              end
            end
          end
          crtc_pkg::OP_TICK: begin
            main_raddr = crtc_pkg::IDX_B;
            state_nxt  = crtc_pkg::ST_MAIN_RD;
          end
          default: begin
            state_nxt = crtc_pkg::ST_DONE;
          end
        endcase
      end

      crtc_pkg::ST_MAIN_RD: begin
        state_nxt = crtc_pkg::ST_DONE;
        case (op_r)
          crtc_pkg::OP_DATA_RD: begin
            res_rd_nxt = mval;
            if (reg_index_r == crtc_pkg::IDX_C) begin
              // reading C acknowledges the interrupt flags
              main_we    = 1'b1;
              main_waddr = crtc_pkg::IDX_C;
              main_wdata = crtc_pkg::BYTE_ZERO;
            end else if (reg_index_r == crtc_pkg::IDX_A) begin
              res_rd_nxt = {upd_r, mval[6:0]};
            end else if (reg_index_r == crtc_pkg::IDX_D) begin
              if (mval == crtc_pkg::BYTE_ZERO) begin
                main_we    = 1'b1;
                main_waddr = crtc_pkg::IDX_D;
                main_wdata = crtc_pkg::D_VRT;
                res_rd_nxt = crtc_pkg::D_VRT;
              end
            end else if (idx_is_ext) begin
              if (ptr_in_ext) begin
                state_nxt = crtc_pkg::ST_EXT_RD;
              end else begin
                res_rd_nxt = crtc_pkg::BYTE_NONE;
              end
            end
          end
          crtc_pkg::OP_DATA_WR: begin
            ext_we = ptr_in_ext;
          end
          crtc_pkg::OP_TICK: begin
            b_nxt     = mval;
            step_nxt  = 3'd0;
            state_nxt = crtc_pkg::ST_TICK;
          end
          default: begin
            state_nxt = crtc_pkg::ST_DONE;
          end
        endcase
      end

      crtc_pkg::ST_EXT_RD: begin
        res_rd_nxt = ext_val;
        state_nxt  = crtc_pkg::ST_DONE;
      end

      crtc_pkg::ST_TICK: begin
        if (step_r == 3'd0) begin
          main_we     = b_r[6];
          main_waddr  = crtc_pkg::IDX_C;
          main_wdata  = crtc_pkg::C_IRQ_FLAG;
          res_irq_nxt = b_r[6];
          // SET bit freezes the time bytes
          if (b_r[7]) begin
            state_nxt = crtc_pkg::ST_DONE;
          end else begin
            step_nxt = step_r + 3'd1;
          end
        end else begin
          main_we    = 1'b1;
          main_waddr = tick_addr;
          main_wdata = bcd_out;
          if (step_r == crtc_pkg::TICK_LAST) begin
            state_nxt = crtc_pkg::ST_DONE;
          end else begin
            step_nxt = step_r + 3'd1;
          end
        end
      end

      crtc_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = crtc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = crtc_pkg::ST_IDLE;
      end
    endcase
  end

  // main store memory, unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (main_we) begin
      main_mem[main_waddr[crtc_pkg::MAIN_AW-1:0]] <= main_wdata;
    end
    main_rd_r <= main_mem[main_raddr[crtc_pkg::MAIN_AW-1:0]];
    main_rv_r <= main_vld_r[main_raddr[crtc_pkg::MAIN_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= '0;
    end else if (main_we) begin
      main_vld_r[main_waddr[crtc_pkg::MAIN_AW-1:0]] <= 1'b1;
    end
  end

  // extended store memory
  always_ff @(posedge clk) begin
    if (ext_we) begin
      ext_mem[ext_addr[crtc_pkg::EXT_AW-1:0]] <= data_r;
    end
    ext_rd_r <= ext_mem[ext_addr[crtc_pkg::EXT_AW-1:0]];
    ext_rv_r <= ext_vld_r[ext_addr[crtc_pkg::EXT_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_vld_r <= '0;
    end else if (ext_we) begin
      ext_vld_r[ext_addr[crtc_pkg::EXT_AW-1:0]] <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rd_r  <= res_rd_r;
      out_irq_r <= res_irq_r;
      out_chg_r <= res_chg_r;
      out_sel_r <= res_sel_r;
    end
  end

endmodule

### rtl/crtc_checker.sv
// port-level checker for the cmos rtc register file, with its bind
`include "cmos_rtc_register_file_unit_macros.svh"

module crtc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_read_data,
  input logic       out_irq,
  input logic       out_rate_changed,
  input logic [3:0] out_rate_select
);

  // a tick or a data write never carries a read byte
  `CRTC_ASSERT_NOW(a_flags_no_data, out_valid && (out_irq || out_rate_changed), out_read_data == crtc_pkg::BYTE_NONE && !(out_irq && out_rate_changed), "irq or rate change with read data")

  `CRTC_ASSERT_NOW(a_sel_only_on_change, out_valid && !out_rate_changed, out_rate_select == 4'd0, "rate select without a write to A")

  // one transaction at a time inside the sequencer
  `CRTC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready right after accept")

  `CRTC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_read_data) && $stable(out_irq) && $stable(out_rate_changed) && $stable(out_rate_select), "stalled result changed")

endmodule

bind cmos_rtc_register_file_unit crtc_checker u_crtc_checker (.*);
